// File: src/sha_pkg.sv
// SHA-256 hasher package: round constants, initial chain, command/status types.
// No dependencies.
`timescale 1ns / 1ps
package sha_pkg;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_ROUND [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,32'h923f82a4,
    32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,32'h72be5d74,32'h80deb1fe,
    32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,
    32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,
    32'hc6e00bf3,32'hd5a79147,32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,
    32'h53380d13,32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,32'h19a4c116,
    32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,32'h5b9cca4f,32'h682e6ff3,
    32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,32'h90befffa,32'ha4506ceb,32'hbef9a3f7,
    32'hc67178f2
  };

  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [5:0] LEN_OFFSET  = 6'd56;

  // byte source selected by the controller when writing the block buffer
  typedef enum logic [1:0] {
    BSEL_DATA = 2'd0,
    BSEL_PAD  = 2'd1,
    BSEL_ZERO = 2'd2,
    BSEL_LEN  = 2'd3
  } byte_sel_e;

  typedef struct packed {
    logic      wr_byte;     // write one byte at fill position, advance fill
    byte_sel_e byte_sel;
    logic      count_len;   // count a message byte
    logic      start_blk;   // load working vars from chain, round 0
    logic      do_round;    // one compression round
    logic      finish_blk;  // fold working vars into chain, clear fill
    logic      clear_msg;   // restore initial chain and zero length
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       last_round;
  } dp_stat_t;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned s);
    ror32 = (x >> s) | (x << (32 - s));
  endfunction

endpackage

// File: src/sha_if.sv
// Valid/ready channel interface used for the input and output streams.
// Payload type is a parameter.
`timescale 1ns / 1ps
interface sha_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/sha_datapath.sv
// SHA-256 datapath: block buffer, schedule, working vars, chain, length.
// Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        data_byte_i,
  input  sha_pkg::dp_cmd_t  cmd_i,
  output sha_pkg::dp_stat_t stat_o,
  output logic [31:0]       chain_o [8]
);
  import sha_pkg::*;

  logic [31:0] buf_q [16];
  logic [5:0]  fill_q, fill_d;
  logic [63:0] len_q, len_d;
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [5:0]  rnd_q;
  logic [7:0]  wbyte;
  logic [63:0] bits;
  logic [31:0] w_new, wt, t1, t2, a, e, x15, x2;

  assign bits = {len_q[60:0], 3'b000};

  always_comb begin
    unique case (cmd_i.byte_sel)
      BSEL_DATA: wbyte = data_byte_i;
      BSEL_PAD:  wbyte = PAD_BYTE;
      BSEL_ZERO: wbyte = 8'h00;
      BSEL_LEN:  wbyte = bits[{3'd7 - fill_q[2:0], 3'b000} +: 8];
      default:   wbyte = 8'h00;
    endcase
  end

  // buffer held as 16 big-endian words; rounds 0..15 read word rnd_q
  // schedule is held as a 16-word shift line, w_q[0] is oldest
  always_comb begin
    x15   = w_q[1];
    x2    = w_q[14];
    w_new = w_q[0] + (ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3)) + w_q[9]
          + (ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10));
    wt    = (rnd_q < 6'd16) ? buf_q[rnd_q[3:0]] : w_new;
    a  = v_q[0];
    e  = v_q[4];
    t1 = v_q[7] + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
       + ((e & v_q[5]) ^ (~e & v_q[6])) + K_ROUND[rnd_q] + wt;
    t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22))
       + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  always_comb begin
    fill_d = fill_q;
    len_d  = len_q;
    if (cmd_i.wr_byte) fill_d = fill_q + 6'd1;
    if (cmd_i.finish_blk) fill_d = '0;
    if (cmd_i.count_len) len_d = len_q + 64'd1;
    if (cmd_i.clear_msg) begin
      fill_d = '0;
      len_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      len_q  <= '0;
      rnd_q  <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= H_INIT[i];
    end else begin
      fill_q <= fill_d;
      len_q  <= len_d;
      if (cmd_i.start_blk) rnd_q <= '0;
      else if (cmd_i.do_round) rnd_q <= rnd_q + 6'd1;
      if (cmd_i.clear_msg)
        for (int i = 0; i < 8; i++) h_q[i] <= H_INIT[i];
      else if (cmd_i.finish_blk)
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_byte) buf_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= wbyte;
    if (cmd_i.start_blk) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (cmd_i.do_round) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= e;
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= a;
      v_q[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wt;
    end
  end

  assign stat_o.fill       = fill_q;
  assign stat_o.last_round = (rnd_q == 6'd63);
  assign chain_o = h_q;
endmodule

// File: src/sha_ctrl.sv
// SHA-256 controller: accepts requests, sequences padding, rounds and digest output.
// Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              has_byte_i,
  input  logic              eom_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [2:0]        out_idx_o,
  input  sha_pkg::dp_stat_t stat_i,
  output sha_pkg::dp_cmd_t  cmd_o
);
  import sha_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ROUND = 7'b0000010,
    S_PAD   = 7'b0000100,
    S_ZERO  = 7'b0001000,
    S_LEN   = 7'b0010000,
    S_OUT   = 7'b0100000,
    S_FOLD  = 7'b1000000
  } state_e;

  state_e     state_q, state_d;
  logic       eom_q, eom_d;    // padding pending after current block
  logic       fin_q, fin_d;    // current block is the final one
  logic       pad_open_q, pad_open_d;  // pad byte written, digest not yet out
  logic [2:0] idx_q, idx_d;

  always_comb begin
    state_d    = state_q;
    eom_d      = eom_q;
    fin_d      = fin_q;
    pad_open_d = pad_open_q;
    idx_d      = idx_q;
    cmd_o      = '0;
    cmd_o.byte_sel = BSEL_DATA;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (has_byte_i) begin
            cmd_o.wr_byte   = 1'b1;
            cmd_o.count_len = 1'b1;
          end
          eom_d = eom_i;
          fin_d = 1'b0;
          if (has_byte_i && stat_i.fill == 6'd63) begin
            cmd_o.start_blk = 1'b1;
            state_d = S_ROUND;
          end else if (eom_i) begin
            state_d = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd_o.wr_byte  = 1'b1;
        cmd_o.byte_sel = BSEL_PAD;
        eom_d      = 1'b0;
        pad_open_d = 1'b1;
        state_d = (stat_i.fill == LEN_OFFSET - 6'd1) ? S_LEN : S_ZERO;
        if (stat_i.fill == 6'd63) begin
          cmd_o.start_blk = 1'b1;
          state_d = S_ROUND;
        end
      end
      S_ZERO: begin
        cmd_o.wr_byte  = 1'b1;
        cmd_o.byte_sel = BSEL_ZERO;
        if (stat_i.fill == 6'd63) begin
          cmd_o.start_blk = 1'b1;
          state_d = S_ROUND;
        end else if (stat_i.fill == LEN_OFFSET - 6'd1 && !eom_q) begin
          state_d = S_LEN;
        end
      end
      S_LEN: begin
        cmd_o.wr_byte  = 1'b1;
        cmd_o.byte_sel = BSEL_LEN;
        if (stat_i.fill == 6'd63) begin
          cmd_o.start_blk = 1'b1;
          fin_d   = 1'b1;
          state_d = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd_o.do_round = 1'b1;
        if (stat_i.last_round) state_d = S_FOLD;
      end
      S_FOLD: begin
        // fold after round 63 has settled into the working vars
        cmd_o.finish_blk = 1'b1;
        if (fin_q) begin
          idx_d   = '0;
          state_d = S_OUT;
        end else if (eom_q) begin
          state_d = S_PAD;
        end else if (pad_open_q) begin
          // pad overflowed the block: zero fill and length go in a new one
          state_d = S_ZERO;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        pad_open_d  = 1'b0;
        if (out_ready_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            cmd_o.clear_msg = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      eom_q      <= 1'b0;
      fin_q      <= 1'b0;
      idx_q      <= '0;
      pad_open_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      eom_q      <= eom_d;
      fin_q      <= fin_d;
      idx_q      <= idx_d;
      pad_open_q <= pad_open_d;
    end
  end

  assign out_idx_o = idx_q;
endmodule

// File: src/sha256_byte_stream_hasher.sv
// SHA-256 byte-stream hasher top level: controller plus datapath.
// Depends on sha_pkg, sha_stream_if, sha_ctrl, sha_datapath.
//
//  channel | dir | payload                                       | accept
//  in_if   | in  | data_byte[7:0], has_byte, end_of_message      | valid & ready
//  out_if  | out | digest_word[31:0], word_index[2:0], last_word | valid & ready
//
// A request with a byte writes it into the block buffer; a request that fills the block
// also runs 64 rounds (one per cycle) and then a fold into the chain.
// End of message adds padding writes (one byte per cycle, up to 72 over two
// blocks) and one or two compressed blocks, then eight digest words, one per
// cycle when unstalled.
// Reset restores the initial chain and clears length and fill; no clear pass.
// Input is not taken while rounds, padding or digest output are in progress.
`timescale 1ns / 1ps
module sha256_byte_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  sha_stream_if.sink   in_if,
  sha_stream_if.source out_if
);
  import sha_pkg::*;

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [31:0] chain [8];
  logic [2:0]  idx;

  sha_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .has_byte_i  (in_if.data.has_byte),
    .eom_i       (in_if.data.end_of_message),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .out_idx_o   (idx),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sha_datapath u_dp (
    .clk_i, .rst_ni,
    .data_byte_i (in_if.data.data_byte),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .chain_o     (chain)
  );

  assign out_if.data.digest_word = chain[idx];
  assign out_if.data.word_index  = idx;
  assign out_if.data.last_word   = (idx == 3'd7);
endmodule

// File: src/sha_checker.sv
// Port-level checker for the SHA-256 hasher, bound to the top level.
// Depends on sha_stream_if.
`timescale 1ns / 1ps
module sha_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] word_index_i,
  input logic       last_word_i
);
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("input taken during digest");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (last_word_i == (word_index_i == 3'd7))) else $error("last flag");
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_word_i |=>
      out_valid_i && word_index_i == $past(word_index_i) + 3'd1)
    else $error("index step");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(word_index_i))
    else $error("stall hold");
endmodule

bind sha256_byte_stream_hasher sha_checker u_chk (
  .clk_i, .rst_ni,
  .in_valid_i (in_if.valid), .in_ready_i (in_if.ready),
  .out_valid_i (out_if.valid), .out_ready_i (out_if.ready),
  .word_index_i (out_if.data.word_index), .last_word_i (out_if.data.last_word)
);

// File: dv/sha_tb_pkg.sv
// Request and response payload types for the SHA-256 hasher testbench.
// Depends on nothing; used by the checker and the testbench top.
`timescale 1ns / 1ps
package sha_tb_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } byte_req_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_rsp_t;

endpackage

// File: dv/sha_digest_checker.sv
// Watches both channels of the SHA-256 hasher, predicts digests, compares them.
// Depends on sha_pkg (constants) and sha_tb_pkg (payload types).
`timescale 1ns / 1ps
module sha_digest_checker
  import sha_pkg::*;
  import sha_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  byte_req_t   req_i,
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  digest_rsp_t rsp_i,
  output int          fails_o,
  output int          pending_o
);

  logic [31:0] hash_words [8];
  logic [7:0]  msg_block [64];
  int          block_fill;
  logic [63:0] byte_count;
  digest_rsp_t digest_q [$];
  int          fail_cnt = 0;
  int          pend_cnt = 0;

  assign fails_o   = fail_cnt;
  assign pending_o = pend_cnt;

  function automatic logic [31:0] rotr32(logic [31:0] x, int s);
    return (x >> s) | (x << (32 - s));
  endfunction

  task automatic compress_msg_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int t = 0; t < 16; t++)
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = rotr32(w[t-15], 7) ^ rotr32(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rotr32(w[t-2], 17) ^ rotr32(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    for (int j = 0; j < 8; j++) v[j] = hash_words[j];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (rotr32(v[4], 6) ^ rotr32(v[4], 11) ^ rotr32(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_ROUND[t] + w[t];
      t2 = (rotr32(v[0], 2) ^ rotr32(v[0], 13) ^ rotr32(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) hash_words[j] += v[j];
  endtask

  task automatic start_message();
    for (int j = 0; j < 8; j++) hash_words[j] = H_INIT[j];
    block_fill = 0;
    byte_count = '0;
  endtask

  task automatic absorb_request(byte_req_t r);
    logic [63:0] bit_len;
    digest_rsp_t d;
    if (r.has_byte) begin
      msg_block[block_fill] = r.data_byte;
      block_fill++;
      byte_count++;
      if (block_fill == 64) begin
        compress_msg_block();
        block_fill = 0;
      end
    end
    if (!r.end_of_message) return;
    bit_len = byte_count << 3;
    msg_block[block_fill] = PAD_BYTE;
    block_fill++;
    if (block_fill > 56) begin
      while (block_fill < 64) msg_block[block_fill++] = 8'h00;
      compress_msg_block();
      block_fill = 0;
    end
    while (block_fill < 56) msg_block[block_fill++] = 8'h00;
    for (int k = 0; k < 8; k++) msg_block[56+k] = bit_len[63-8*k -: 8];
    compress_msg_block();
    for (int k = 0; k < 8; k++) begin
      d.digest_word = hash_words[k];
      d.word_index  = 3'(k);
      d.last_word   = (k == 7);
      digest_q = {digest_q, d};
    end
    start_message();
  endtask

  initial start_message();

  always @(posedge clk_i) begin
    digest_rsp_t exp_d;
    if (rst_ni) begin
      if (req_valid_i && req_ready_i) absorb_request(req_i);
      if (rsp_valid_i && rsp_ready_i) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest word %h idx %0d last %0b", $time,
                   rsp_i.digest_word, rsp_i.word_index, rsp_i.last_word);
          fail_cnt++;
        end else begin
          exp_d = digest_q.pop_front();
          if (rsp_i.digest_word !== exp_d.digest_word) begin
            $display("%0t: digest_word expected %h actual %h", $time,
                     exp_d.digest_word, rsp_i.digest_word);
            fail_cnt++;
          end
          if (rsp_i.word_index !== exp_d.word_index) begin
            $display("%0t: word_index expected %0d actual %0d", $time,
                     exp_d.word_index, rsp_i.word_index);
            fail_cnt++;
          end
          if (rsp_i.last_word !== exp_d.last_word) begin
            $display("%0t: last_word expected %0b actual %0b", $time,
                     exp_d.last_word, rsp_i.last_word);
            fail_cnt++;
          end
        end
      end
    end
    pend_cnt = digest_q.size();
  end

endmodule

// File: dv/sha256_byte_stream_hasher_tb.sv
// Testbench top for sha256_byte_stream_hasher: clock, reset, byte stimulus, verdict.
// Depends on sha_pkg, sha_tb_pkg, sha_stream_if, sha_digest_checker and the block.
`timescale 1ns / 1ps
module sha256_byte_stream_hasher_tb;
  import sha_tb_pkg::*;

  localparam int MAX_CYCLES  = 300000;
  localparam int TAIL_CYCLES = 300;  // settle time for any stray output
  localparam int HOLD_CYCLES = 400;  // long receiver stall

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sha_stream_if #(.T(byte_req_t))   in_if ();
  sha_stream_if #(.T(digest_rsp_t)) out_if ();

  int fails;
  int pending;
  int cycle_cnt = 0;
  int burst_left = 0;
  int req_cnt = 0;
  bit hold_req = 1'b0;

  sha256_byte_stream_hasher i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  sha_digest_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_if.valid),
    .req_ready_i (in_if.ready),
    .req_i       (in_if.data),
    .rsp_valid_i (out_if.valid),
    .rsp_ready_i (out_if.ready),
    .rsp_i       (out_if.data),
    .fails_o     (fails),
    .pending_o   (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: phases of steady, choppy and mostly-ready stalls. One long hold
  // lets the block back up and stall its input while requests keep coming.
  initial begin : receiver
    int mode;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) begin
          @(posedge clk_i);
          out_if.ready <= 1'b0;
        end
      end
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(10, 60)) begin
        @(posedge clk_i);
        case (mode)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= $urandom_range(0, 1);
          default: out_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // One request; gaps between bursts are inserted ahead of it.
  // ready is sampled at the falling edge so the accept check is race free.
  task automatic send_request(logic [7:0] b, logic has_b, logic eom);
    byte_req_t r;
    logic acc;
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 8)) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    r.data_byte      = b;
    r.has_byte       = has_b;
    r.end_of_message = eom;
    in_if.valid <= 1'b1;
    in_if.data  <= r;
    do begin
      @(negedge clk_i);
      acc = in_if.ready;
      @(posedge clk_i);
    end while (!acc);
    req_cnt++;
  endtask

  // Random message: byte requests with idle noise; the end flag either rides
  // on the last byte or comes as a request of its own.
  task automatic send_message(int len);
    bit split_end;
    split_end = (len == 0) || $urandom_range(0, 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_request(8'($urandom), 1'b0, 1'b0);
      send_request(8'($urandom), 1'b1, (i == len - 1) && !split_end);
    end
    if (split_end) send_request(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin : stimulus
    int sel;
    int len;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty message, "abc", extreme bytes, idle requests
    send_request(8'h5a, 1'b0, 1'b1);
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'hff, 1'b0, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b1);
    send_request(8'hff, 1'b1, 1'b1);
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'hff, 1'b0, 1'b1);
    send_request(8'h00, 1'b0, 1'b0);
    send_request(8'haa, 1'b1, 1'b0);
    send_request(8'h55, 1'b1, 1'b1);

    // random part; the long hold starts with it
    hold_req = 1'b1;
    while (req_cnt < 150) begin
      sel = $urandom_range(0, 9);
      if (sel < 6)       len = $urandom_range(0, 12);
      else if (sel == 6) len = $urandom_range(53, 57);  // one vs two pad blocks
      else if (sel == 7) len = $urandom_range(62, 66);  // full-block boundary
      else               len = $urandom_range(1, 30);
      send_message(len);
    end
    in_if.valid <= 1'b0;

    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
